// ----- rtl/epm_pkg.sv -----
// Shared types, constants and the twist table for the entropy pool mixer.
package epm_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [12:0] entropy_bits;
        logic [6:0]  written_index;
        word_t       written_word;
    } result_t;

    localparam int unsigned NUM_TAPS = 5;

    localparam logic [4:0] ROT_STEP      = 5'd7;
    localparam logic [4:0] ROT_STEP_WRAP = 5'd14;

    function automatic word_t twist_word(input logic [2:0] sel);
        word_t w;
        case (sel)
            3'd0:    w = 32'h0000_0000;
            3'd1:    w = 32'h3b6e_20c8;
            3'd2:    w = 32'h76dc_4190;
            3'd3:    w = 32'h4db2_6158;
            3'd4:    w = 32'hedb8_8320;
            3'd5:    w = 32'hd6d6_a3e8;
            3'd6:    w = 32'h9b64_c2b0;
            3'd7:    w = 32'ha00a_e278;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/entropy_pool_mixer.sv -----
// Top level of the entropy pool mixer: cell chain, tap select, counters and APB registers.
//
// Takes one word per cycle while the skid entry is empty; its result goes into the output
// register, and a one-entry skid lets a further word be taken while a result is stalled.
// The pool is a row of POOL_WORDS cells that rotates one place for each mixed word, so
// the insert position is read at the last cell and written at the first, and each feedback
// tap is a fixed cell picked by its register. A whole mix (rotate, XOR with six pool words,
// twist, write back) runs through the five tap multiplexers, which set the clock rate.
// Reset clears the pool at once, with no clearing pass. POOL_WORDS must be a power of two.
module entropy_pool_mixer
    import epm_pkg::*;
#(
    parameter int unsigned POOL_WORDS = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mix_enable,
    input  logic [31:0]        s_sample_word,
    input  logic signed [13:0] s_entropy_credit,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [12:0]        m_entropy_bits,
    output logic [6:0]         m_written_index,
    output logic [31:0]        m_written_word,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned IDX_W   = $clog2(POOL_WORDS);
    localparam int unsigned MAX_ENT = 32 * POOL_WORDS;
    localparam int unsigned ENT_W   = $clog2(MAX_ENT + 1);
    localparam int unsigned SUM_W   = ENT_W + 15;

    localparam logic [6:0] TAP_RESET [NUM_TAPS] = '{7'd103, 7'd76, 7'd51, 7'd25, 7'd1};

    logic [6:0]       tap_reg [NUM_TAPS];
    logic [IDX_W-1:0] tap_sel [NUM_TAPS];
    logic [17:0]      tap_wide [NUM_TAPS];
    logic [2:0]       reg_idx;
    logic             cfg_wr;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [4:0]       rot_reg, rot_next;
    logic [ENT_W-1:0] ent_reg, ent_next;

    logic             s_fire;
    logic             mix_fire;
    word_t            cell_words [POOL_WORDS];
    word_t            tap_words [NUM_TAPS];
    word_t            mixed_word;

    logic signed [SUM_W-1:0] ent_sum;
    logic [IDX_W+6:0]        idx_wide;
    logic [ENT_W+13:0]       ent_wide;
    result_t                 result;
    result_t                 out_data;

    // ---------------- configuration ----------------
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                tap_reg[k] <= TAP_RESET[k];
            end
        end else begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                if (cfg_wr && reg_idx == 3'(k)) begin
                    tap_reg[k] <= pwdata[6:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            if (reg_idx == 3'(k)) begin
                prdata = {25'd0, tap_reg[k]};
            end
        end
    end

    // tap t sits one cell behind its offset
    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            tap_wide[k]  = {11'd0, tap_reg[k]};
            tap_sel[k]   = tap_wide[k][IDX_W-1:0] - IDX_W'(1);
            tap_words[k] = cell_words[tap_sel[k]];
        end
    end

    // ---------------- cell chain ----------------
    assign s_fire   = s_valid && s_ready;
    assign mix_fire = s_fire && s_mix_enable;

    for (genvar c = 0; c < POOL_WORDS; c++) begin : g_cell
        word_t cell_in;
        if (c == 0) begin : g_head
            assign cell_in = mixed_word;
        end else begin : g_body
            assign cell_in = cell_words[c-1];
        end
        epm_pool_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (mix_fire),
            .word_in  (cell_in),
            .word_out (cell_words[c])
        );
    end

    epm_mixer u_mixer (
        .sample_word (s_sample_word),
        .rot_amt     (rot_reg),
        .tap_words   (tap_words),
        .cur_word    (cell_words[POOL_WORDS-1]),
        .mixed_word  (mixed_word)
    );

    // ---------------- counters ----------------
    always_comb begin
        idx_next = idx_reg;
        rot_next = rot_reg;
        if (mix_fire) begin
            idx_next = idx_reg - IDX_W'(1);
            rot_next = rot_reg + ((idx_next == '0) ? ROT_STEP_WRAP : ROT_STEP);
        end

        ent_sum = $signed({15'd0, ent_reg})
                + $signed({{(SUM_W-14){s_entropy_credit[13]}}, s_entropy_credit});
        if (ent_sum[SUM_W-1]) begin
            ent_next = '0;
        end else if (ent_sum > $signed(SUM_W'(MAX_ENT))) begin
            ent_next = ENT_W'(MAX_ENT);
        end else begin
            ent_next = ent_sum[ENT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            rot_reg <= '0;
            ent_reg <= '0;
        end else if (s_fire) begin
            idx_reg <= idx_next;
            rot_reg <= rot_next;
            ent_reg <= ent_next;
        end
    end

    // ---------------- result ----------------
    always_comb begin
        idx_wide             = {7'd0, idx_next};
        ent_wide             = {14'd0, ent_next};
        result.entropy_bits  = ent_wide[12:0];
        result.written_index = s_mix_enable ? idx_wide[6:0] : 7'd0;
        result.written_word  = s_mix_enable ? mixed_word : '0;
    end

    epm_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_entropy_bits  = out_data.entropy_bits;
    assign m_written_index = out_data.written_index;
    assign m_written_word  = out_data.written_word;

`ifndef SYNTHESIS
    a_credit_only_keeps_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_mix_enable |=> $stable(idx_reg) && $stable(rot_reg))
        else $error("credit-only word moved the insert position or rotate");

    a_entropy_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> ent_reg <= ENT_W'(MAX_ENT))
        else $error("entropy count above pool capacity");

    a_stall_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");
`endif

endmodule

// ----- rtl/epm_pool_cell.sv -----
// One pool word of the rotating cell chain.
module epm_pool_cell
    import epm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift_en,
    input  word_t word_in,
    output word_t word_out
);

    word_t word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else if (shift_en) begin
            word_reg <= word_in;
        end
    end

    assign word_out = word_reg;

endmodule

// ----- rtl/epm_mixer.sv -----
// Rotate, tap feedback and twist for one mixed word.
module epm_mixer
    import epm_pkg::*;
(
    input  word_t      sample_word,
    input  logic [4:0] rot_amt,
    input  word_t      tap_words [NUM_TAPS],
    input  word_t      cur_word,
    output word_t      mixed_word
);

    logic [63:0] dbl;
    word_t       rotated;
    word_t       acc;

    always_comb begin
        // top half of a doubled word shifted left is the rotate; zero passes as is
        dbl     = {sample_word, sample_word} << rot_amt;
        rotated = dbl[63:32];
        acc     = rotated ^ cur_word;
        for (int k = 0; k < NUM_TAPS; k++) begin
            acc = acc ^ tap_words[k];
        end
        mixed_word = {3'b000, acc[31:3]} ^ twist_word(acc[2:0]);
    end

endmodule

// ----- rtl/epm_out_skid.sv -----
// Output register with one skid entry for the result channel.
module epm_out_skid
    import epm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    in_fire;

    always_comb begin
        in_fire         = in_valid && !skid_valid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_data_next  = in_data;
                out_valid_next = in_fire;
            end
        end else if (in_fire) begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- test/tb_entropy_pool_mixer.sv -----
// Self-checking testbench for the entropy pool mixer: directed table, random words, tap phases.
module tb_entropy_pool_mixer;
    import epm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POOL_SIZE    = 128;
    localparam int unsigned PERIOD       = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned HOLD_AT      = 300;
    localparam int          ENTROPY_CEIL = 32 * POOL_SIZE;

    localparam word_t TWIST [8] = '{
        32'h0000_0000, 32'h3b6e_20c8, 32'h76dc_4190, 32'h4db2_6158,
        32'hedb8_8320, 32'hd6d6_a3e8, 32'h9b64_c2b0, 32'ha00a_e278
    };

    localparam logic [NUM_TAPS-1:0][6:0] TAPS_DEFAULT = {7'd1, 7'd25, 7'd51, 7'd76, 7'd103};
    localparam logic [NUM_TAPS-1:0][6:0] TAPS_LOW     = '0;
    localparam logic [NUM_TAPS-1:0][6:0] TAPS_HIGH    = '1;

    typedef struct packed {
        logic        mix;
        word_t       word;
        logic [13:0] credit;
        logic        typed;
        result_t     want;
    } stim_row_t;

    localparam int unsigned NUM_ROWS = 20;

    // rows with typed results start straight after reset, pool all zero
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        {1'b0, 32'h0000_0000, 14'h0000, 1'b1, {13'd0,    7'd0,   32'h0}},
        {1'b0, 32'hffff_ffff, 14'h1fff, 1'b1, {13'd4096, 7'd0,   32'h0}},
        {1'b0, 32'h0000_0000, 14'h2000, 1'b1, {13'd0,    7'd0,   32'h0}},
        {1'b1, 32'h0000_0000, 14'h1000, 1'b1, {13'd4096, 7'd127, 32'h0}},
        {1'b1, 32'h0000_0000, 14'h3000, 1'b1, {13'd0,    7'd126, 32'h0}},
        {1'b0, 32'ha5a5_a5a5, 14'h0000, 1'b1, {13'd0,    7'd0,   32'h0}},
        {1'b1, 32'h0000_0001, 14'h0001, 1'b0, 52'h0},
        {1'b1, 32'hffff_ffff, 14'h1fff, 1'b0, 52'h0},
        {1'b1, 32'h8000_0000, 14'h3fff, 1'b0, 52'h0},
        {1'b1, 32'h7fff_ffff, 14'h2000, 1'b0, 52'h0},
        {1'b1, 32'h0000_0007, 14'h0fff, 1'b0, 52'h0},
        {1'b1, 32'hffff_fff8, 14'h0002, 1'b0, 52'h0},
        {1'b1, 32'hdead_beef, 14'h3ffd, 1'b0, 52'h0},
        {1'b0, 32'hffff_ffff, 14'h3fff, 1'b0, 52'h0},
        {1'b1, 32'h0000_ffff, 14'h0064, 1'b0, 52'h0},
        {1'b1, 32'hffff_0000, 14'h3f9c, 1'b0, 52'h0},
        {1'b1, 32'h5555_5555, 14'h1000, 1'b0, 52'h0},
        {1'b1, 32'haaaa_aaaa, 14'h1fff, 1'b0, 52'h0},
        {1'b1, 32'h0000_0000, 14'h2000, 1'b0, 52'h0},
        {1'b1, 32'h1234_5678, 14'h0000, 1'b0, 52'h0}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mix_enable;
    logic [31:0]        s_sample_word;
    logic signed [13:0] s_entropy_credit;
    logic               m_valid;
    logic               m_ready;
    logic [12:0]        m_entropy_bits;
    logic [6:0]         m_written_index;
    logic [31:0]        m_written_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // mirror of the block's state
    word_t      pool_mirror [POOL_SIZE];
    logic [6:0] slot;
    logic [4:0] spin;
    int         credit_total;
    logic [6:0] tap_mirror [NUM_TAPS];

    result_t     pending_results [$];
    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;

    entropy_pool_mixer #(
        .POOL_WORDS(POOL_SIZE)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mix_enable     (s_mix_enable),
        .s_sample_word    (s_sample_word),
        .s_entropy_credit (s_entropy_credit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_entropy_bits   (m_entropy_bits),
        .m_written_index  (m_written_index),
        .m_written_word   (m_written_word),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h, want %0h (t=%0t)", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic result_t mix_word(input logic mix, input word_t word,
                                         input logic signed [13:0] credit);
        result_t    r;
        word_t      w;
        logic [6:0] at;
        int         sum;
        r = '0;
        if (mix) begin
            w = (spin == 5'd0) ? word : ((word << spin) | (word >> (32 - spin)));
            slot = slot - 7'd1;
            spin = spin + ((slot == 7'd0) ? ROT_STEP_WRAP : ROT_STEP);
            for (int k = 0; k < NUM_TAPS; k++) begin
                at = slot + tap_mirror[k];
                w ^= pool_mirror[at];
            end
            w ^= pool_mirror[slot];
            w = (w >> 3) ^ TWIST[w[2:0]];
            pool_mirror[slot] = w;
            r.written_index = slot;
            r.written_word  = w;
        end
        sum = credit_total + int'(credit);
        if (sum < 0)
            sum = 0;
        else if (sum > ENTROPY_CEIL)
            sum = ENTROPY_CEIL;
        credit_total = sum;
        r.entropy_bits = 13'(credit_total);
        return r;
    endfunction

    // offer one word after a gap; returns at the edge that takes it
    task automatic send_word(input logic mix, input word_t word, input logic signed [13:0] credit,
                             input int unsigned gap, input logic typed, input result_t want);
        result_t predicted;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_mix_enable     <= mix;
        s_sample_word    <= word;
        s_entropy_credit <= credit;
        do @(posedge aclk); while (!s_ready);
        predicted = mix_word(mix, word, credit);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_random(input int unsigned count);
        logic               mix;
        word_t              word;
        logic signed [13:0] credit;
        bit                 quiet;
        quiet = 1'b0;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            mix = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       word = 32'h0000_0000;
                1:       word = 32'hffff_ffff;
                default: word = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: credit = 14'($urandom_range(0, 16383));
                1: begin
                    case ($urandom_range(0, 3))
                        0:       credit = -14'sd8192;
                        1:       credit = 14'sd8191;
                        2:       credit = -14'sd4096;
                        default: credit = 14'sd4096;
                    endcase
                end
                default: credit = 14'($urandom_range(0, 200)) - 14'sd100;
            endcase
            send_word(mix, word, credit, quiet ? 0 : $urandom_range(0, 13), 1'b0, '0);
        end
    endtask

    // block is idle once every expected word is back
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_taps(input logic [NUM_TAPS-1:0][6:0] vals);
        for (int k = 0; k < NUM_TAPS; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 5'(k << 2);
            pwdata  <= 32'(vals[k]);
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            tap_mirror[k] = vals[k];
            // read back
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            if (prdata !== 32'(vals[k]))
                report_mismatch($sformatf("tap register %0d readback", k), prdata, vals[k]);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        logic [NUM_TAPS-1:0][6:0] random_taps;
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_mix_enable     <= 1'b0;
        s_sample_word    <= '0;
        s_entropy_credit <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        for (int k = 0; k < POOL_SIZE; k++)
            pool_mirror[k] = '0;
        slot         = '0;
        spin         = '0;
        credit_total = 0;
        for (int k = 0; k < NUM_TAPS; k++)
            tap_mirror[k] = TAPS_DEFAULT[k];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset tap values first
        for (int r = 0; r < NUM_ROWS; r++)
            send_word(DIRECTED_ROWS[r].mix, DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].credit,
                      $urandom_range(0, 13), DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        send_random(150);
        drain();

        set_taps(TAPS_LOW);
        send_random(100);
        drain();

        set_taps(TAPS_HIGH);
        send_random(100);
        drain();

        for (int k = 0; k < NUM_TAPS; k++)
            random_taps[k] = 7'($urandom_range(0, 127));
        set_taps(random_taps);
        send_random(150);
        drain();

        set_taps(TAPS_DEFAULT);
        send_random(150);
        drain();

        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        result_t     want;
        int unsigned stall;
        bit          quiet;
        bit          held;
        quiet = 1'b0;
        held  = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (results_seen % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            // one long hold-off lets the input side back up
            if (!held && results_seen >= HOLD_AT) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 13);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none expected", m_written_word, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_entropy_bits !== want.entropy_bits)
                    report_mismatch("entropy_bits", m_entropy_bits, want.entropy_bits);
                if (m_written_index !== want.written_index)
                    report_mismatch("written_index", m_written_index, want.written_index);
                if (m_written_word !== want.written_word)
                    report_mismatch("written_word", m_written_word, want.written_word);
            end
        end
    end

endmodule

// ----- files.f -----
rtl/epm_pkg.sv
rtl/epm_pool_cell.sv
rtl/epm_mixer.sv
rtl/epm_out_skid.sv
rtl/entropy_pool_mixer.sv
test/tb_entropy_pool_mixer.sv
